/* hw/rtl/beam_top_k_sorted_list_defines.svh */
// assertion macros for the beam top-k list
`ifndef BEAM_TOP_K_SORTED_LIST_DEFINES_SVH
`define BEAM_TOP_K_SORTED_LIST_DEFINES_SVH

// same-cycle implication
`define BTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bts check failed");

// next-cycle implication
`define BTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bts check failed");

`endif

/* hw/rtl/bts_pkg.sv */
`default_nettype none
package bts_pkg;

   localparam int unsigned LIST_SLOTS_DEF    = 16;
   localparam int unsigned HANDLE_W          = 32;
   localparam int unsigned SCORE_W           = 32;
   localparam int unsigned WIDTH_W           = 5;
   localparam int unsigned RANK_W            = 4;
   localparam int unsigned BEAM_WIDTH_RESET  = 16;

   // result kinds
   localparam logic KIND_DROP = 1'b0;
   localparam logic KIND_LEAF = 1'b1;

   typedef struct packed {
      logic [HANDLE_W-1:0]        handle;
      logic signed [SCORE_W-1:0]  score;
   } bts_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DROP,
      ST_DRAIN_RD,
      ST_DRAIN_OUT
   } bts_state_type;

endpackage
`default_nettype wire

/* hw/rtl/bts_req_if.sv */
`default_nettype none
interface bts_req_if import bts_pkg::*;;

   logic                       valid;
   logic                       ready;
   logic [HANDLE_W-1:0]        cand_handle;
   logic signed [SCORE_W-1:0]  cand_score;
   logic                       end_of_step;

   modport source (output valid, output cand_handle, output cand_score,
                   output end_of_step, input ready);
   modport sink   (input valid, input cand_handle, input cand_score,
                   input end_of_step, output ready);

endinterface
`default_nettype wire

/* hw/rtl/bts_rsp_if.sv */
`default_nettype none
interface bts_rsp_if import bts_pkg::*;;

   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [HANDLE_W-1:0]        out_handle;
   logic signed [SCORE_W-1:0]  out_score;
   logic [RANK_W-1:0]          rank;
   logic                       last;

   modport source (output valid, output kind, output out_handle, output out_score,
                   output rank, output last, input ready);
   modport sink   (input valid, input kind, input out_handle, input out_score,
                   input rank, input last, output ready);

endinterface
`default_nettype wire

/* hw/rtl/beam_top_k_sorted_list.sv */
// Beam-search top-k list: keeps up to beam_width candidates sorted by signed
// score, best first, in a single-port-read / single-port-write list memory.
// A candidate enters behind all entries of equal or higher score. When the
// list is full, either the displaced last entry or the candidate itself leaves
// as a dropped result (kind 0). With end_of_step set, the whole list follows
// as kind-1 leaves in rank order, then the list is empty; last marks the
// final result of each input. The insertion walks the list from its tail,
// one memory read per cycle, moving each lower entry down one slot; a full
// list is first checked against its last entry, and a candidate that loses
// that check skips the walk and leaves as a drop. A dropped result and an
// end-of-step drain wait while the result side stalls; the walk itself does
// not. The list memory has one registered read port. The user must write
// beam_width through csr_we/csr_wdata only while the block is idle; the block
// does not enforce this. 0 acts as 1, values above LIST_SLOTS act as LIST_SLOTS,
// and shrinking it silently discards the entries beyond the new width.
`default_nettype none
module beam_top_k_sorted_list import bts_pkg::*; #(
   parameter int unsigned LIST_SLOTS = LIST_SLOTS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   bts_req_if.sink                 req_chan,
   bts_rsp_if.source               rsp_chan,
   input  wire logic               csr_we,
   input  wire logic [WIDTH_W-1:0] csr_wdata
);

   // list index and fill count widths
   localparam int unsigned IW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
   localparam int unsigned CW = $clog2(LIST_SLOTS + 1);

   // clamp the programmed width to 1..LIST_SLOTS
   function automatic logic [CW-1:0] eff_of(input logic [WIDTH_W-1:0] bw);
      logic [CW-1:0] res;
      if (bw == '0) begin
         res = CW'(1);
      end else if (int'(bw) > int'(LIST_SLOTS)) begin
         res = CW'(LIST_SLOTS);
      end else begin
         res = CW'(bw);
      end
      return res;
   endfunction

   // list memory, entries kept in rank order
   bts_entry_type list_mem [LIST_SLOTS];
   bts_entry_type rd_entry_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   bts_entry_type mem_wdata;
   logic          mem_re;
   logic [IW-1:0] mem_raddr;

   // control state
   bts_state_type state_ff, state_in;
   logic [WIDTH_W-1:0] beam_width_ff, beam_width_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      pos_ff, pos_in;          // slot the walk will write next
   logic [CW-1:0]      drain_ff, drain_in;      // rank being drained
   logic               full_ff, full_in;
   logic               first_ff, first_in;
   logic               drop_pend_ff, drop_pend_in;

   // candidate and dropped entry being worked on
   bts_entry_type cand_ff, cand_in;
   logic          eos_ff, eos_in;
   bts_entry_type drop_ff, drop_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   bts_entry_type      rsp_entry_ff, rsp_entry_in;
   logic [RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_load;
   logic               out_free;

   logic [CW-1:0] eff_width;
   logic [CW-1:0] eff_new;
   logic [CW-1:0] pos_m1;
   logic [CW-1:0] pos_m2;
   logic [CW-1:0] count_m1;
   logic          cand_wins;

   assign eff_width = eff_of(beam_width_ff);
   assign eff_new   = eff_of(csr_wdata);
   assign pos_m1    = pos_ff - CW'(1);
   assign pos_m2    = pos_m1 - CW'(1);
   assign count_m1  = count_ff - CW'(1);
   // candidate ranks strictly ahead of the entry just read
   assign cand_wins = cand_ff.score > rd_entry_ff.score;
   // output register can take a new result this cycle
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // list memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         list_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_entry_ff <= list_mem[mem_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         beam_width_ff <= WIDTH_W'(BEAM_WIDTH_RESET);
         count_ff      <= '0;
         drop_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         beam_width_ff <= beam_width_in;
         count_ff      <= count_in;
         drop_pend_ff  <= drop_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      drain_ff <= drain_in;
      full_ff  <= full_in;
      first_ff <= first_in;
      cand_ff  <= cand_in;
      eos_ff   <= eos_in;
      drop_ff  <= drop_in;
      if (out_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_entry_ff <= rsp_entry_in;
         rsp_rank_ff  <= rsp_rank_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // sequencer: tail-first insertion walk, dropped result, drain
   always_comb begin
      state_in      = state_ff;
      beam_width_in = beam_width_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      drain_in      = drain_ff;
      full_in       = full_ff;
      first_in      = first_ff;
      drop_pend_in  = drop_pend_ff;
      cand_in       = cand_ff;
      eos_in        = eos_ff;
      drop_in       = drop_ff;

      req_chan.ready = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = pos_ff[IW-1:0];
      mem_wdata      = cand_ff;
      mem_re         = 1'b0;
      mem_raddr      = pos_m2[IW-1:0];

      out_load     = 1'b0;
      rsp_kind_in  = KIND_DROP;
      rsp_entry_in = drop_ff;
      rsp_rank_in  = '0;
      rsp_last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cand_in.handle = req_chan.cand_handle;
               cand_in.score  = req_chan.cand_score;
               eos_in         = req_chan.end_of_step;
               full_in        = (count_ff == eff_width);
               first_in       = 1'b1;
               pos_in         = count_ff;
               drain_in       = '0;
               drop_pend_in   = 1'b0;
               // fetch the current tail entry
               mem_re         = 1'b1;
               mem_raddr      = count_m1[IW-1:0];
               state_in       = ST_SCAN;
            end
         end

         ST_SCAN: begin
            first_in = 1'b0;
            if (first_ff && full_ff) begin
               // full list: candidate or tail entry leaves
               drop_pend_in = 1'b1;
               if (!cand_wins) begin
                  drop_in  = cand_ff;
                  state_in = ST_DROP;
               end else begin
                  drop_in = rd_entry_ff;
                  pos_in  = pos_m1;
                  mem_re  = 1'b1;
               end
            end else if (pos_ff == '0 || !cand_wins) begin
               // insertion point found
               mem_we = 1'b1;
               if (!full_ff) begin
                  count_in = count_ff + CW'(1);
               end
               if (drop_pend_ff) begin
                  state_in = ST_DROP;
               end else if (eos_ff) begin
                  state_in = ST_DRAIN_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               // move the lower entry down one slot and keep walking
               mem_we    = 1'b1;
               mem_wdata = rd_entry_ff;
               pos_in    = pos_m1;
               mem_re    = 1'b1;
            end
         end

         ST_DROP: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_kind_in  = KIND_DROP;
               rsp_entry_in = drop_ff;
               rsp_last_in  = !eos_ff;
               drop_pend_in = 1'b0;
               state_in     = eos_ff ? ST_DRAIN_RD : ST_IDLE;
            end
         end

         ST_DRAIN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = drain_ff[IW-1:0];
            state_in  = ST_DRAIN_OUT;
         end

         ST_DRAIN_OUT: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_kind_in  = KIND_LEAF;
               rsp_entry_in = rd_entry_ff;
               rsp_rank_in  = RANK_W'(drain_ff);
               rsp_last_in  = (drain_ff == count_m1);
               if (drain_ff == count_m1) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  drain_in  = drain_ff + CW'(1);
                  mem_re    = 1'b1;
                  mem_raddr = drain_in[IW-1:0];
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // width write only while idle by user, unchecked; trims list to new width
      if (csr_we) begin
         beam_width_in = csr_wdata;
         if (count_ff > eff_new) begin
            count_in = eff_new;
         end
      end
   end

   // output register: refill on transfer or when empty
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.out_handle = rsp_entry_ff.handle;
   assign rsp_chan.out_score  = rsp_entry_ff.score;
   assign rsp_chan.rank       = rsp_rank_ff;
   assign rsp_chan.last       = rsp_last_ff;

endmodule
`default_nettype wire

/* hw/rtl/bts_checker.sv */
`default_nettype none
`include "beam_top_k_sorted_list_defines.svh"
module bts_checker import bts_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic                      rsp_kind,
   input wire logic [HANDLE_W-1:0]       rsp_handle,
   input wire logic signed [SCORE_W-1:0] rsp_score,
   input wire logic [RANK_W-1:0]         rsp_rank,
   input wire logic                      rsp_last
);

   // a stalled result holds
   `BTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_handle) && $stable(rsp_score) && $stable(rsp_rank) && $stable(rsp_last))

   // dropped candidates carry rank zero
   `BTS_ASSERT_NOW(a_drop_rank, clock, reset, rsp_valid && rsp_kind == KIND_DROP, rsp_rank == '0)

   // leaves stream back to back with rising rank until the last one
   `BTS_ASSERT_NEXT(a_leaf_seq, clock, reset, rsp_valid && rsp_ready && rsp_kind == KIND_LEAF && !rsp_last, rsp_valid && rsp_kind == KIND_LEAF && rsp_rank == RANK_W'($past(rsp_rank) + 1'b1))

   // an accepted item keeps the block busy for at least the next cycle
   `BTS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind beam_top_k_sorted_list bts_checker u_bts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.kind),
   .rsp_handle (rsp_chan.out_handle),
   .rsp_score  (rsp_chan.out_score),
   .rsp_rank   (rsp_chan.rank),
   .rsp_last   (rsp_chan.last)
);
`default_nettype wire

/* dv/tb_beam_top_k_sorted_list.sv */
`default_nettype none
module tb_beam_top_k_sorted_list;
   import bts_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 8;
   // worst item: tail walk over a full list, a drop, then a 16-leaf drain
   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int RUN_LIMIT      = 3000000;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 30;

   // one candidate as offered on the request channel
   typedef struct packed {
      logic [HANDLE_W-1:0]       handle;
      logic signed [SCORE_W-1:0] score;
      logic                      eos;
   } cand_type;

   // one dropped candidate or kept leaf on the result channel
   typedef struct packed {
      logic                      kind;
      logic [HANDLE_W-1:0]       handle;
      logic signed [SCORE_W-1:0] score;
      logic [RANK_W-1:0]         rank;
      logic                      last;
   } outcome_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [WIDTH_W-1:0] csr_wdata;

   bts_req_if req_bus ();
   bts_rsp_if rsp_bus ();

   beam_top_k_sorted_list DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow of the beam list, best score first
   logic [HANDLE_W-1:0]       kept_handle [LIST_SLOTS_DEF];
   logic signed [SCORE_W-1:0] kept_score  [LIST_SLOTS_DEF];
   int unsigned               kept_count;
   logic [WIDTH_W-1:0]        width_reg;

   cand_type    cand_backlog [$];   // candidates not yet offered
   outcome_type awaited [$];        // drops and leaves still to arrive
   cand_type    on_bus;             // candidate currently on the request channel
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          holdoff_armed;
   int unsigned holdoff_count;
   int          fail_count;

   int unsigned phase_width [PHASES] = '{16, 31, 3, 1, 0, 8, 5, 2, 12, 16};

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #RUN_LIMIT;
      $display("tb_beam_top_k_sorted_list: FAIL");
      $finish;
   end

   // width actually used: zero acts as one, above the slot count clamps
   function automatic int unsigned lane_limit();
      int unsigned w;
      w = width_reg;
      if (w < 1)
         w = 1;
      if (w > LIST_SLOTS_DEF)
         w = LIST_SLOTS_DEF;
      return w;
   endfunction

   function automatic void post_outcome(logic kind, logic [HANDLE_W-1:0] handle,
                                        logic signed [SCORE_W-1:0] score, int unsigned pos);
      outcome_type o;
      o.kind   = kind;
      o.handle = handle;
      o.score  = score;
      o.rank   = RANK_W'(pos);
      o.last   = 1'b0;
      awaited.push_back(o);
   endfunction

   // insert one accepted candidate and queue what it causes
   function automatic void rank_candidate(cand_type c);
      int unsigned w, pos, k, first;
      bit          placed;
      outcome_type tail;
      w     = lane_limit();
      first = awaited.size();
      if (kept_count > w)
         kept_count = w;
      // goes in front of the first strictly lower score, so ties keep arrival order
      pos    = kept_count;
      placed = 1'b0;
      for (k = 0; k < kept_count; k++) begin
         if (!placed && $signed(c.score) > $signed(kept_score[k])) begin
            pos    = k;
            placed = 1'b1;
         end
      end
      if (pos < kept_count) begin
         // full list pushes out its last entry
         if (kept_count == w)
            post_outcome(KIND_DROP, kept_handle[w-1], kept_score[w-1], 0);
         else
            kept_count++;
         for (k = kept_count - 1; k > pos; k--) begin
            kept_handle[k] = kept_handle[k-1];
            kept_score[k]  = kept_score[k-1];
         end
         kept_handle[pos] = c.handle;
         kept_score[pos]  = c.score;
      end else if (kept_count < w) begin
         kept_handle[kept_count] = c.handle;
         kept_score[kept_count]  = c.score;
         kept_count++;
      end else begin
         // ranks below a full list: the candidate itself is dropped
         post_outcome(KIND_DROP, c.handle, c.score, 0);
      end
      // end of step: emit every kept entry in rank order, then clear
      if (c.eos) begin
         for (k = 0; k < kept_count; k++)
            post_outcome(KIND_LEAF, kept_handle[k], kept_score[k], k);
         kept_count = 0;
      end
      if (awaited.size() > first) begin
         tail      = awaited.pop_back();
         tail.last = 1'b1;
         awaited.push_back(tail);
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   // sender: holds each candidate until the transfer, idles at random between
   always @(posedge clock) begin : cand_driver
      bit take;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            rank_candidate(on_bus);
         if (!req_bus.valid || req_bus.ready) begin
            take = cand_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
            if (take) begin
               on_bus = cand_backlog.pop_front();
               req_bus.cand_handle <= on_bus.handle;
               req_bus.cand_score  <= on_bus.score;
               req_bus.end_of_step <= on_bus.eos;
            end
            req_bus.valid <= take;
         end
      end
   end

   // receiver: checks every result transfer against the oldest expectation
   always @(posedge clock) begin : leaf_monitor
      outcome_type want;
      bit          hold;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited.size() == 0) begin
               $error("unexpected result: kind %0d handle %h score %h",
                      rsp_bus.kind, rsp_bus.out_handle, rsp_bus.out_score);
               fail_count++;
            end else begin
               want = awaited.pop_front();
               check_field("kind", want.kind, rsp_bus.kind);
               check_field("out_handle", want.handle, rsp_bus.out_handle);
               check_field("out_score", want.score, rsp_bus.out_score);
               check_field("rank", want.rank, rsp_bus.rank);
               check_field("last", want.last, rsp_bus.last);
            end
         end
         // one long hold-off so the list backs up and the input stalls
         hold = 1'b0;
         if (holdoff_armed && holdoff_count < HOLDOFF_CYCLES) begin
            hold = 1'b1;
            holdoff_count++;
         end
         rsp_bus.ready <= !hold && $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   function automatic bit busy();
      return cand_backlog.size() != 0 || req_bus.valid || awaited.size() != 0;
   endfunction

   function automatic void offer(logic [HANDLE_W-1:0] handle, logic [SCORE_W-1:0] score,
                                 logic eos);
      cand_type c;
      c.handle = handle;
      c.score  = score;
      c.eos    = eos;
      cand_backlog.push_back(c);
   endfunction

   // mix of full-range, tie-prone and extreme scores
   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return 32'($urandom_range(0, 6)) - 32'd3;
         default: return $urandom;
      endcase
   endfunction

   // wait for all results, then for any silent insertion still walking the list
   task automatic settle();
      do @(negedge clock); while (busy());
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_width(logic [WIDTH_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      // shrinking silently drops entries past the new width
      width_reg = value;
      if (kept_count > lane_limit())
         kept_count = lane_limit();
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.cand_handle = '0;
      req_bus.cand_score  = '0;
      req_bus.end_of_step = 1'b0;
      rsp_bus.ready       = 1'b0;
      kept_count          = 0;
      width_reg           = BEAM_WIDTH_RESET;
      holdoff_armed       = 1'b0;
      holdoff_count       = 0;
      fail_count          = 0;
      send_idle_pct       = 26;
      recv_idle_pct       = 45;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single best candidate with end of step at reset width
      offer(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      // extremes, ties in arrival order, a new best and a negative score
      offer(32'h0000_0000, 32'h8000_0000, 1'b0);
      offer(32'h0000_0001, 32'h0000_0000, 1'b0);
      offer(32'h0000_0002, 32'h0000_0000, 1'b0);
      offer(32'h0000_0003, 32'h7FFF_FFFF, 1'b0);
      offer(32'h0000_0004, 32'hFFFF_FFFF, 1'b0);
      offer(32'h0000_0005, 32'h0000_0001, 1'b1);
      settle();

      // width one: tie drops the newcomer, better score displaces the entry
      write_width(5'd1);
      offer(32'h0000_0010, 32'h0000_0005, 1'b0);
      offer(32'h0000_0011, 32'h0000_0005, 1'b0);
      offer(32'h0000_0012, 32'h0000_0006, 1'b0);
      offer(32'h0000_0013, 32'h8000_0000, 1'b1);
      settle();

      // width zero behaves as one
      write_width(5'd0);
      offer(32'h0000_0020, 32'h0000_0000, 1'b0);
      offer(32'h0000_0021, 32'h0000_0001, 1'b1);
      settle();

      // shrink mid-step from four entries to two
      write_width(5'd4);
      offer(32'h0000_0030, 32'd100, 1'b0);
      offer(32'h0000_0031, 32'd200, 1'b0);
      offer(32'h0000_0032, 32'd300, 1'b0);
      offer(32'h0000_0033, 32'd50, 1'b0);
      settle();
      write_width(5'd2);
      offer(32'h0000_0034, 32'd150, 1'b1);
      settle();

      // random phases over widths, idling patterns and one long hold-off
      for (int p = 0; p < PHASES; p++) begin
         write_width(phase_width[p][WIDTH_W-1:0]);
         if (p < 4) begin
            send_idle_pct = 26;
            recv_idle_pct = 45;
         end else if (p < 7) begin
            send_idle_pct = 45;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 2)
            holdoff_armed = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++)
            offer($urandom, pick_score(), $urandom_range(0, lane_limit() + 2) == 0);
         // sender pauses here until every expected result has come
         settle();
      end

      // closing step flushes whatever the last phase left in the list
      offer($urandom, pick_score(), 1'b1);
      for (int i = 0; i < DRAIN_LIMIT && busy(); i++)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (busy()) begin
         $error("%0d results never arrived", awaited.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("tb_beam_top_k_sorted_list: PASS");
      else
         $display("tb_beam_top_k_sorted_list: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
